// File: rtl/xrrg_pkg.sv
package xrrg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  bit_cnt_t;
    typedef logic [1:0]        word_idx_t;

    // splitmix32 constants
    localparam word_t GOLDEN_STEP = 32'h9e37_79b9;
    localparam word_t MIX_MUL_A   = 32'h85eb_ca6b;
    localparam word_t MIX_MUL_B   = 32'hc2b2_ae35;
    localparam int unsigned MIX_SH_A = 16;
    localparam int unsigned MIX_SH_B = 13;

    // xoshiro128** constants
    localparam int unsigned SCR_ROT  = 7;
    localparam int unsigned STEP_SH  = 9;
    localparam int unsigned STEP_ROT = 11;

    localparam word_idx_t LAST_WORD = 2'd3;

    // One state word produced by the seed expansion.
    typedef struct packed {
        logic      vld;
        word_idx_t idx;
        word_t     word;
    } seed_load_t;

    typedef enum logic [1:0] {
        EXP_IDLE,
        EXP_MUL_A,
        EXP_MUL_B
    } exp_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DIV,
        ST_OUT
    } top_state_t;

    function automatic word_t rotl(input word_t v, input int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

// File: rtl/xrrg_seed_expand.sv
// Splitmix32 seed expansion. Each of the two multiplications per step is a
// shift-and-add over one multiplier bit per cycle.
module xrrg_seed_expand
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  xrrg_pkg::word_t     wr_data,
    output xrrg_pkg::seed_load_t load,
    output logic                busy
);

    xrrg_pkg::exp_state_t state_reg, state_next;
    xrrg_pkg::word_t      seed_reg, seed_next;
    logic                 pend_reg, pend_next;
    xrrg_pkg::word_t      ctr_reg, ctr_next;
    xrrg_pkg::word_t      mcand_reg, mcand_next;
    xrrg_pkg::word_t      acc_reg, acc_next;
    xrrg_pkg::bit_cnt_t   cnt_reg, cnt_next;
    xrrg_pkg::word_idx_t  idx_reg, idx_next;

    xrrg_pkg::word_t base;
    xrrg_pkg::word_t ctr_inc;
    xrrg_pkg::word_t prod;
    logic            mul_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xrrg_pkg::EXP_IDLE;
            seed_reg  <= '0;
            pend_reg  <= 1'b1;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg   <= ctr_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        seed_next  = seed_reg;
        pend_next  = pend_reg;
        ctr_next   = ctr_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        load       = '0;

        base    = (state_reg == xrrg_pkg::EXP_IDLE) ? seed_reg : ctr_reg;
        ctr_inc = base + xrrg_pkg::GOLDEN_STEP;
        mul_bit = (state_reg == xrrg_pkg::EXP_MUL_A) ? xrrg_pkg::MIX_MUL_A[cnt_reg]
                                                     : xrrg_pkg::MIX_MUL_B[cnt_reg];
        prod    = acc_reg + (mul_bit ? mcand_reg : '0);

        case (state_reg)
            xrrg_pkg::EXP_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    ctr_next   = ctr_inc;
                    mcand_next = ctr_inc ^ (ctr_inc >> xrrg_pkg::MIX_SH_A);
                    acc_next   = '0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = xrrg_pkg::EXP_MUL_A;
                end
            end
            xrrg_pkg::EXP_MUL_A:
            begin
                acc_next   = prod;
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg + xrrg_pkg::bit_cnt_t'(1);
                if (&cnt_reg)
                begin
                    mcand_next = prod ^ (prod >> xrrg_pkg::MIX_SH_B);
                    acc_next   = '0;
                    state_next = xrrg_pkg::EXP_MUL_B;
                end
            end
            xrrg_pkg::EXP_MUL_B:
            begin
                acc_next   = prod;
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg + xrrg_pkg::bit_cnt_t'(1);
                if (&cnt_reg)
                begin
                    load.vld  = 1'b1;
                    load.idx  = idx_reg;
                    load.word = prod ^ (prod >> xrrg_pkg::MIX_SH_A);
                    if (idx_reg == xrrg_pkg::LAST_WORD)
                    begin
                        state_next = xrrg_pkg::EXP_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + xrrg_pkg::word_idx_t'(1);
                        ctr_next   = ctr_inc;
                        mcand_next = ctr_inc ^ (ctr_inc >> xrrg_pkg::MIX_SH_A);
                        acc_next   = '0;
                        state_next = xrrg_pkg::EXP_MUL_A;
                    end
                end
            end
            default:
            begin
                state_next = xrrg_pkg::EXP_IDLE;
            end
        endcase

        // A new seed restarts the expansion from the first word.
        if (wr_en)
        begin
            seed_next  = wr_data;
            pend_next  = 1'b1;
            state_next = xrrg_pkg::EXP_IDLE;
            load       = '0;
        end

        busy = pend_reg | (state_reg != xrrg_pkg::EXP_IDLE);
    end

endmodule

// File: rtl/xrrg_gen_state.sv
// Generator state words with the output scrambler, whose product by five and final result are each registered.
module xrrg_gen_state
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  xrrg_pkg::seed_load_t load,
    input  logic                 draw,
    output xrrg_pkg::word_t      raw,
    output logic                 raw_vld
);

    xrrg_pkg::word_t words_reg [4];
    xrrg_pkg::word_t words_next [4];
    xrrg_pkg::word_t p5_reg, p5_next;
    xrrg_pkg::word_t raw_reg, raw_next;
    logic            p5_vld_reg;
    logic            raw_vld_reg;

    xrrg_pkg::word_t t;
    xrrg_pkg::word_t r;
    xrrg_pkg::word_t n0, n1, n2, n3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_vld_reg  <= 1'b0;
            raw_vld_reg <= 1'b0;
        end
        else
        begin
            p5_vld_reg  <= draw;
            raw_vld_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            words_reg[i] <= words_next[i];
        end
        p5_reg  <= p5_next;
        raw_reg <= raw_next;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            words_next[i] = words_reg[i];
        end

        t  = words_reg[1] << xrrg_pkg::STEP_SH;
        n2 = words_reg[2] ^ words_reg[0];
        n3 = words_reg[3] ^ words_reg[1];
        n1 = words_reg[1] ^ n2;
        n0 = words_reg[0] ^ n3;

        if (load.vld)
        begin
            words_next[load.idx] = load.word;
        end
        else if (draw)
        begin
            words_next[0] = n0;
            words_next[1] = n1;
            words_next[2] = n2 ^ t;
            words_next[3] = xrrg_pkg::rotl(n3, xrrg_pkg::STEP_ROT);
        end

        // Multiplications by five and nine are single shift-and-add steps.
        p5_next  = words_reg[1] + (words_reg[1] << 2);
        r        = xrrg_pkg::rotl(p5_reg, xrrg_pkg::SCR_ROT);
        raw_next = r + (r << 3);
    end

    assign raw     = raw_reg;
    assign raw_vld = raw_vld_reg;

endmodule

// File: rtl/xrrg_rem_div.sv
// Restoring remainder, one dividend bit per cycle. A zero divisor leaves
// the dividend as the remainder.
module xrrg_rem_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  xrrg_pkg::word_t dividend,
    input  xrrg_pkg::word_t divisor,
    output xrrg_pkg::word_t rem,
    output logic            done
);

    xrrg_pkg::word_t    dvd_reg, dvd_next;
    xrrg_pkg::word_t    dsr_reg, dsr_next;
    xrrg_pkg::word_t    rem_reg, rem_next;
    xrrg_pkg::bit_cnt_t cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [xrrg_pkg::WORD_W:0]   part;
    logic [xrrg_pkg::WORD_W+1:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        part = {rem_reg, dvd_reg[xrrg_pkg::WORD_W-1]};
        diff = {1'b0, part} - {2'b00, dsr_reg};

        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = diff[xrrg_pkg::WORD_W+1] ? part[xrrg_pkg::WORD_W-1:0]
                                                : diff[xrrg_pkg::WORD_W-1:0];
            cnt_next = cnt_reg + xrrg_pkg::bit_cnt_t'(1);
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// File: rtl/xoshiro_random_range_generator_unit.sv
// Random range generator on a xoshiro128** core. Each input item carries two
// signed 32-bit bounds in either order; the block returns one signed value
// drawn uniformly-by-remainder from the inclusive range between them, and
// advances the generator by one step. After the item is accepted, the
// result passes through the scrambler, the start of the remainder unit, its
// bit-serial remainder, the addition of the lower bound and the load of the
// output register, where it is offered. The next item can be accepted once
// the result is loaded, so a new item is taken only after the last one is
// through; a result still waiting downstream holds the block until it is
// taken. One item is worked on at a time, but a finished result may wait in
// the output register while the next item is accepted. Writing the seed
// register re-expands the generator state with four splitmix32 steps whose
// multiplications run one bit per cycle; s_tready is low in the cycle of the
// write and for the whole expansion after it. The same expansion of seed
// zero runs after reset.
module xoshiro_random_range_generator_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // [31:0] range_low, [63:32] range_high

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [31:0] value

    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data
);

    xrrg_pkg::top_state_t state_reg, state_next;
    xrrg_pkg::word_t      low_reg, low_next;
    xrrg_pkg::word_t      span_reg, span_next;
    xrrg_pkg::word_t      res_reg, res_next;
    xrrg_pkg::word_t      out_reg, out_next;
    logic                 out_vld_reg, out_vld_next;

    xrrg_pkg::seed_load_t load;
    logic                 exp_busy;
    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic                 out_load;
    logic                 out_free;
    xrrg_pkg::word_t      raw;
    logic                 raw_vld;
    xrrg_pkg::word_t      rem;
    xrrg_pkg::word_t      lo_in;
    xrrg_pkg::word_t      hi_in;
    xrrg_pkg::word_t      lo_ord;
    xrrg_pkg::word_t      hi_ord;

    xrrg_seed_expand u_expand
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (seed_wr_en),
        .wr_data (seed_wr_data),
        .load    (load),
        .busy    (exp_busy)
    );

    xrrg_gen_state u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .draw    (accept),
        .raw     (raw),
        .raw_vld (raw_vld)
    );

    xrrg_rem_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (raw),
        .divisor  (span_reg),
        .rem      (rem),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= xrrg_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        span_reg <= span_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Bounds are put in order with a signed compare; the span wraps at 32
    // bits, so the full range gives a zero span, which the remainder unit
    // passes through as the raw word.
    assign lo_in  = s_tdata[31:0];
    assign hi_in  = s_tdata[63:32];
    assign lo_ord = ($signed(lo_in) > $signed(hi_in)) ? hi_in : lo_in;
    assign hi_ord = ($signed(lo_in) > $signed(hi_in)) ? lo_in : hi_in;

    assign s_tready = (state_reg == xrrg_pkg::ST_IDLE) && !exp_busy && !seed_wr_en;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        span_next  = span_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            xrrg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    low_next   = lo_ord;
                    span_next  = hi_ord - lo_ord + xrrg_pkg::word_t'(1);
                    state_next = xrrg_pkg::ST_DRAW;
                end
            end
            xrrg_pkg::ST_DRAW:
            begin
                if (raw_vld)
                begin
                    div_start  = 1'b1;
                    state_next = xrrg_pkg::ST_DIV;
                end
            end
            xrrg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = low_reg + rem;
                    state_next = xrrg_pkg::ST_OUT;
                end
            end
            xrrg_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = xrrg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xrrg_pkg::ST_IDLE;
            end
        endcase

        // The output register holds a result until the downstream side
        // takes it, independent of the work on the next item.
        out_next     = out_load ? res_reg : out_reg;
        out_vld_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

// File: rtl/xrrg_checker.sv
module xrrg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        seed_wr_en
);

    // A result that has not been taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // No item is taken in the cycle of a seed write.
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr_en |-> !s_tready)
        else $error("item accepted during a seed write");

    // A seed write starts a long expansion, so no item follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr_en |=> !s_tready)
        else $error("ready straight after a seed write");

    // One item at a time: ready drops after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in progress");

endmodule

bind xoshiro_random_range_generator_unit xrrg_checker u_xrrg_checker (.*);
